// ----- rtl/core/rdcw_pkg.sv -----
`timescale 1ns / 1ps

package rdcw_pkg;

    localparam int MAX_ELEMENTS = 32768;
    localparam int VALUE_RANGE  = 65536;

    // fixed field widths of the stream items
    localparam int CMD_FW = 1;
    localparam int IDX_FW = 15;
    localparam int VAL_FW = 16;
    localparam int RNG_FW = 16;
    localparam int TOT_FW = 16;

    localparam int IN_FW   = IDX_FW + VAL_FW + 2 * RNG_FW;
    localparam int IN_TW   = ((IN_FW + 7) / 8) * 8;
    localparam int OUT_TW  = ((TOT_FW + 7) / 8) * 8;

    localparam int IDX_LSB = 0;
    localparam int VAL_LSB = IDX_LSB + IDX_FW;
    localparam int LFT_LSB = VAL_LSB + VAL_FW;
    localparam int RGT_LSB = LFT_LSB + RNG_FW;

    // storage widths
    localparam int EA_W  = $clog2(MAX_ELEMENTS);
    localparam int CA_W  = $clog2(VALUE_RANGE);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int POS_W = CNT_W;

    localparam logic [CMD_FW-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_FW-1:0] CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [IDX_FW-1:0] load_index;
        logic [VAL_FW-1:0] load_value;
        logic [RNG_FW-1:0] range_left;
        logic [RNG_FW-1:0] range_right;
    } t_in_item;

endpackage

// ----- rtl/core/rdcw_ram.sv -----
`timescale 1ns / 1ps

module rdcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/range_distinct_count_window.sv -----
`timescale 1ns / 1ps

// Distinct-value count over a sliding window of a loaded element array. After reset the
// value histogram memory is swept to zero, one entry a cycle, across all VALUE_RANGE
// (65536) entries, and no item is taken during the sweep. A load outside the current
// window is written to the element store in the cycle it is accepted; one whose position
// lies inside the window also takes the old value out of the histogram and puts the new
// value in. A query walks the window edges from the previous range one position at a
// time: each moved position costs an element read, a histogram read and a histogram
// write-back through the single read port of each memory. A range that is empty,
// reversed or beyond the array returns 0 and leaves the window as it is. A query whose
// result finds the previous one still untaken waits in its finish step until that
// transfer completes. Ranges are one-based and inclusive; queries are answered in arrival order.
module range_distinct_count_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // load_index, load_value, range_left, range_right, zero fill
    input  logic [rdcw_pkg::IN_TW-1:0] s_axis_tdata,
    // cmd
    input  logic [rdcw_pkg::CMD_FW-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // distinct_total
    output logic [rdcw_pkg::OUT_TW-1:0] m_axis_tdata
);

    import rdcw_pkg::*;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_WALK    = 3'd2;
    localparam logic [2:0] S_CNT_RD  = 3'd3;
    localparam logic [2:0] S_CNT_WR  = 3'd4;
    localparam logic [2:0] S_LOAD_UP = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    localparam logic [1:0] RET_WALK = 2'd0;
    localparam logic [1:0] RET_LOAD = 2'd1;
    localparam logic [1:0] RET_IDLE = 2'd2;

    t_in_item          w_item;
    logic              w_acc;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_ret, n_ret;
    logic              r_up, n_up;
    logic [CA_W-1:0]   r_clr, n_clr;
    logic [POS_W-1:0]  r_wlo, n_wlo;
    logic [POS_W-1:0]  r_whi, n_whi;
    logic [POS_W-1:0]  r_lo, n_lo;
    logic [POS_W-1:0]  r_hi, n_hi;
    logic [CNT_W-1:0]  r_tally, n_tally;
    logic [CA_W-1:0]   r_val, n_val;
    logic [EA_W-1:0]   r_lidx, n_lidx;
    logic [CA_W-1:0]   r_lval, n_lval;
    logic [CNT_W-1:0]  r_res, n_res;
    logic              r_out_valid, n_out_valid;
    logic [TOT_FW-1:0] r_out_data, n_out_data;

    logic              e_we;
    logic [EA_W-1:0]   e_waddr, e_raddr;
    logic [CA_W-1:0]   e_wdata, e_rdata;
    logic              c_we;
    logic [CA_W-1:0]   c_waddr, c_raddr;
    logic [CNT_W-1:0]  c_wdata, c_rdata;

    assign w_item = t_in_item'({s_axis_tdata[IDX_LSB +: IDX_FW],
                                s_axis_tdata[VAL_LSB +: VAL_FW],
                                s_axis_tdata[LFT_LSB +: RNG_FW],
                                s_axis_tdata[RGT_LSB +: RNG_FW]});
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    rdcw_ram #(.WIDTH(CA_W), .DEPTH(MAX_ELEMENTS)) u_elem (
        .i_clk  (i_clk),
        .i_we   (e_we),
        .i_waddr(e_waddr),
        .i_wdata(e_wdata),
        .i_raddr(e_raddr),
        .o_rdata(e_rdata)
    );

    rdcw_ram #(.WIDTH(CNT_W), .DEPTH(VALUE_RANGE)) u_hist (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    always_comb begin
        logic            load_ok;
        logic            in_window;
        logic            bad_rng;
        logic [POS_W-1:0] idx_pos;

        n_state     = r_state;
        n_ret       = r_ret;
        n_up        = r_up;
        n_clr       = r_clr;
        n_wlo       = r_wlo;
        n_whi       = r_whi;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_tally     = r_tally;
        n_val       = r_val;
        n_lidx      = r_lidx;
        n_lval      = r_lval;
        n_res       = r_res;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;

        e_we    = 1'b0;
        e_waddr = EA_W'(w_item.load_index);
        e_wdata = CA_W'(w_item.load_value);
        e_raddr = EA_W'(w_item.load_index);
        c_we    = 1'b0;
        c_waddr = r_val;
        c_wdata = c_rdata;
        c_raddr = r_val;

        load_ok   = (32'(w_item.load_index) < 32'(MAX_ELEMENTS))
                 && (32'(w_item.load_value) < 32'(VALUE_RANGE));
        idx_pos   = POS_W'(w_item.load_index);
        in_window = (idx_pos >= r_wlo) && (idx_pos < r_whi);
        bad_rng   = (w_item.range_left == '0)
                 || (w_item.range_left > w_item.range_right)
                 || (32'(w_item.range_right) > 32'(MAX_ELEMENTS));

        case (r_state)
            S_CLEAR: begin
                c_we    = 1'b1;
                c_waddr = r_clr;
                c_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == CA_W'(VALUE_RANGE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    if (s_axis_tuser == CMD_LOAD) begin
                        if (load_ok) begin
                            n_lidx = EA_W'(w_item.load_index);
                            n_lval = CA_W'(w_item.load_value);
                            if (in_window) begin
                                n_up    = 1'b0;
                                n_ret   = RET_LOAD;
                                n_state = S_CNT_RD;
                            end else begin
                                e_we = 1'b1;
                            end
                        end
                    end else if (bad_rng) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_lo    = POS_W'(w_item.range_left - 1'b1);
                        n_hi    = POS_W'(w_item.range_right);
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                n_ret   = RET_WALK;
                n_state = S_CNT_RD;
                if (r_wlo > r_lo) begin
                    n_wlo   = r_wlo - 1'b1;
                    e_raddr = EA_W'(r_wlo - 1'b1);
                    n_up    = 1'b1;
                end else if (r_whi < r_hi) begin
                    n_whi   = r_whi + 1'b1;
                    e_raddr = EA_W'(r_whi);
                    n_up    = 1'b1;
                end else if (r_wlo < r_lo) begin
                    n_wlo   = r_wlo + 1'b1;
                    e_raddr = EA_W'(r_wlo);
                    n_up    = 1'b0;
                end else if (r_whi > r_hi) begin
                    n_whi   = r_whi - 1'b1;
                    e_raddr = EA_W'(r_whi - 1'b1);
                    n_up    = 1'b0;
                end else begin
                    n_res   = r_tally;
                    n_state = S_DONE;
                end
            end
            S_CNT_RD: begin
                c_raddr = e_rdata;
                n_val   = e_rdata;
                n_state = S_CNT_WR;
                // old value is out of the element store, new one may go in
                if (r_ret == RET_LOAD) begin
                    e_we    = 1'b1;
                    e_waddr = r_lidx;
                    e_wdata = r_lval;
                end
            end
            S_CNT_WR: begin
                c_we = 1'b1;
                if (r_up) begin
                    c_wdata = c_rdata + 1'b1;
                    if (c_rdata == '0) begin
                        n_tally = r_tally + 1'b1;
                    end
                end else if (c_rdata != '0) begin
                    c_wdata = c_rdata - 1'b1;
                    if (c_rdata == CNT_W'(1)) begin
                        n_tally = r_tally - 1'b1;
                    end
                end
                case (r_ret)
                    RET_WALK: n_state = S_WALK;
                    RET_LOAD: n_state = S_LOAD_UP;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_LOAD_UP: begin
                c_raddr = r_lval;
                n_val   = r_lval;
                n_up    = 1'b1;
                n_ret   = RET_IDLE;
                n_state = S_CNT_WR;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = TOT_FW'(r_res);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= RET_IDLE;
            r_up        <= 1'b0;
            r_clr       <= '0;
            r_wlo       <= '0;
            r_whi       <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_up        <= n_up;
            r_clr       <= n_clr;
            r_wlo       <= n_wlo;
            r_whi       <= n_whi;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_tally     <= n_tally;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_lidx     <= n_lidx;
        r_lval     <= n_lval;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'(r_out_data);

`ifndef SYNTHESIS
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wlo <= r_whi) && (32'(r_whi) <= 32'(MAX_ELEMENTS)))
        else $error("window edges out of order");

    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_tally <= CNT_W'(r_whi - r_wlo)))
        else $error("distinct tally exceeds window size");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the finish step");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");

    a_walk_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> (r_state == S_CNT_RD) || (r_state == S_DONE))
        else $error("walk step left the update sequence");
`endif

endmodule
